### rtl/dspe_pkg.sv
// shared types, command codes and defaults for the dag source peel engine
package dspe_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int VCNT_W           = 6;
  localparam int VIDX_W           = 5;
  localparam int MASK_W           = 32;

  localparam logic [VCNT_W-1:0] VCNT_RESET = 6'd32;

  localparam logic [1:0] CMD_WRITE_EDGE = 2'd0;
  localparam logic [1:0] CMD_FIND       = 2'd1;
  localparam logic [1:0] CMD_PEEL       = 2'd2;

  typedef struct packed {
    logic [1:0]        command;
    logic [VIDX_W-1:0] src_vertex;
    logic [VIDX_W-1:0] dst_vertex;
    logic              edge_present;
  } in_item_t;

  typedef struct packed {
    logic [MASK_W-1:0] entry_mask;
    logic [MASK_W-1:0] exit_mask;
  } out_item_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic              entry_mode;
    logic              wr_en;
    logic [VIDX_W-1:0] wr_src;
    logic [VIDX_W-1:0] wr_dst;
    logic              wr_bit;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PRED,
    ST_OUT
  } state_t;

endpackage

### rtl/dag_source_peel_engine.sv
// top level: sequencer plus a row of vertex cells holding the adjacency matrix
//
// Usage. Items enter on in_valid/in_ready with an in_item_t word; results leave
// on out_valid/out_ready with an out_item_t word. cfg_we/cfg_wdata set the
// number of vertices in use at any clock while the engine is idle.
// A write-edge command is taken and gives no result; unused
// command codes are taken and dropped the same way.
// Find and peel run an or-scan that travels down the row of MAX_VERTICES
// cells, one cell per cycle. Find runs one such scan between accept and
// result, peel two scans back to back. One find or peel is in flight at
// a time and in_ready is low until its result is in the output register.
// The output register holds a result while out_ready is low; the next edge
// writes are still taken, and a following scan waits only at its final step.
// Reset clears every adjacency row, both masks and sets the vertex count to
// 32, all in the reset cycle.
module dag_source_peel_engine #(
  parameter int MAX_VERTICES = dspe_pkg::MAX_VERTICES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [dspe_pkg::VCNT_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  dspe_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output dspe_pkg::out_item_t         out_data
);
  import dspe_pkg::*;

  localparam int ROW_W = (MAX_VERTICES > 32) ? 32 : MAX_VERTICES;

  cell_ctl_t         ctl;
  logic [MAX_VERTICES-1:0] lm;
  logic [MAX_VERTICES-1:0] entry_set;
  logic [MAX_VERTICES-1:0] exit_flags;
  logic                    launch;
  logic                    wave_vld [0:MAX_VERTICES];
  logic [ROW_W-1:0]        wave_acc [0:MAX_VERTICES];

  assign wave_vld[0] = launch;
  assign wave_acc[0] = '0;

  dspe_ctrl #(
    .MAX_V (MAX_VERTICES),
    .ROW_W (ROW_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .ctl        (ctl),
    .lm         (lm),
    .entry_set  (entry_set),
    .launch     (launch),
    .wave_done  (wave_vld[MAX_VERTICES]),
    .wave_acc   (wave_acc[MAX_VERTICES]),
    .exit_flags (exit_flags)
  );

  for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
    dspe_cell #(
      .IDX   (g),
      .ROW_W (ROW_W)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .lm_row       (lm[ROW_W-1:0]),
      .active       (lm[g]),
      .entry        (entry_set[g]),
      .wave_vld_in  (wave_vld[g]),
      .wave_acc_in  (wave_acc[g]),
      .wave_vld_out (wave_vld[g+1]),
      .wave_acc_out (wave_acc[g+1]),
      .exit_flag    (exit_flags[g])
    );
  end

endmodule

### rtl/dspe_cell.sv
// one vertex cell: holds an adjacency row and forwards the or-scan word
module dspe_cell #(
  parameter int IDX   = 0,
  parameter int ROW_W = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dspe_pkg::cell_ctl_t ctl,
  input  logic [ROW_W-1:0]    lm_row,
  input  logic                active,
  input  logic                entry,
  input  logic                wave_vld_in,
  input  logic [ROW_W-1:0]    wave_acc_in,
  output logic                wave_vld_out,
  output logic [ROW_W-1:0]    wave_acc_out,
  output logic                exit_flag
);
  import dspe_pkg::*;

  logic [ROW_W-1:0] row_r;
  logic [ROW_W-1:0] row_nxt;
  logic [ROW_W-1:0] acc_r;
  logic [ROW_W-1:0] acc_nxt;
  logic             vld_r;
  logic [ROW_W-1:0] wmask;
  logic             participate;
  logic             wr_sel;

  assign participate = active && (!ctl.entry_mode || entry);
  assign wr_sel      = ctl.wr_en && ({1'b0, ctl.wr_src} == (VIDX_W+1)'(IDX));

  always_comb begin
    for (int j = 0; j < ROW_W; j++) begin
      wmask[j] = (ctl.wr_dst == VIDX_W'(j));
    end
  end

  always_comb begin
    row_nxt = row_r;
    acc_nxt = acc_r;
    if (wr_sel) begin
      row_nxt = ctl.wr_bit ? (row_r | wmask) : (row_r & ~wmask);
    end else if (wave_vld_in && participate && ctl.entry_mode) begin
      // peeled entry loses its outgoing edges inside the active range
      row_nxt = row_r & ~lm_row;
    end
    if (wave_vld_in) begin
      acc_nxt = wave_acc_in | (participate ? row_r : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      vld_r <= 1'b0;
    end else begin
      row_r <= row_nxt;
      vld_r <= wave_vld_in;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign wave_vld_out = vld_r;
  assign wave_acc_out = acc_r;
  assign exit_flag    = active && ((row_r & lm_row) == '0);

endmodule

### rtl/dspe_ctrl.sv
// command sequencer: launches scans along the cell row and builds the masks
module dspe_ctrl #(
  parameter int MAX_V = 32,
  parameter int ROW_W = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [dspe_pkg::VCNT_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  dspe_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output dspe_pkg::out_item_t         out_data,
  output dspe_pkg::cell_ctl_t         ctl,
  output logic [MAX_V-1:0]            lm,
  output logic [MAX_V-1:0]            entry_set,
  output logic                        launch,
  input  logic                        wave_done,
  input  logic [ROW_W-1:0]            wave_acc,
  input  logic [MAX_V-1:0]            exit_flags
);
  import dspe_pkg::*;

  state_t            state_r, state_nxt;
  logic [VCNT_W-1:0] vcnt_r, vcnt_nxt;
  logic [MAX_V-1:0]  entry_r, entry_nxt;
  logic [MAX_V-1:0]  exit_r, exit_nxt;
  logic [MAX_V-1:0]  succ_r, succ_nxt;
  logic              launch_r, launch_nxt;
  logic              mode_r, mode_nxt;
  logic              ovld_r, ovld_nxt;
  out_item_t         odata_r, odata_nxt;
  logic [MAX_V-1:0]  acc_ext;
  logic              accept;

  always_comb begin
    for (int i = 0; i < MAX_V; i++) begin
      lm[i] = ((VCNT_W+1)'(i) < {1'b0, vcnt_r});
    end
  end

  assign acc_ext = MAX_V'(wave_acc);
  assign accept  = in_valid && in_ready;

  always_comb begin
    state_nxt  = state_r;
    vcnt_nxt   = cfg_we ? cfg_wdata : vcnt_r;
    entry_nxt  = entry_r;
    exit_nxt   = exit_r;
    succ_nxt   = succ_r;
    launch_nxt = 1'b0;
    mode_nxt   = mode_r;
    ovld_nxt   = (out_ready) ? 1'b0 : ovld_r;
    odata_nxt  = odata_r;
    in_ready   = 1'b0;
    ctl        = '0;
    ctl.entry_mode = mode_r;
    ctl.wr_src     = in_data.src_vertex;
    ctl.wr_dst     = in_data.dst_vertex;
    ctl.wr_bit     = in_data.edge_present;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        ctl.wr_en  = in_valid && (in_data.command == CMD_WRITE_EDGE);
        if (accept && (in_data.command == CMD_FIND || in_data.command == CMD_PEEL)) begin
          launch_nxt = 1'b1;
          mode_nxt   = (in_data.command == CMD_PEEL);
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (wave_done) begin
          if (mode_r) begin
            // successors of the peeled entries, then a fresh predecessor scan
            succ_nxt   = acc_ext & lm;
            mode_nxt   = 1'b0;
            launch_nxt = 1'b1;
            state_nxt  = ST_PRED;
          end else begin
            entry_nxt = lm & ~acc_ext;
            exit_nxt  = exit_flags;
            state_nxt = ST_OUT;
          end
        end
      end
      ST_PRED: begin
        if (wave_done) begin
          entry_nxt = succ_r & ~acc_ext;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ovld_r || out_ready) begin
          ovld_nxt             = 1'b1;
          odata_nxt.entry_mask = MASK_W'(entry_r);
          odata_nxt.exit_mask  = MASK_W'(exit_r);
          state_nxt            = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      vcnt_r   <= VCNT_RESET;
      entry_r  <= '0;
      exit_r   <= '0;
      launch_r <= 1'b0;
      mode_r   <= 1'b0;
      ovld_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      vcnt_r   <= vcnt_nxt;
      entry_r  <= entry_nxt;
      exit_r   <= exit_nxt;
      launch_r <= launch_nxt;
      mode_r   <= mode_nxt;
      ovld_r   <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    succ_r  <= succ_nxt;
    odata_r <= odata_nxt;
  end

  assign entry_set = entry_r;
  assign launch    = launch_r;
  assign out_valid = ovld_r;
  assign out_data  = odata_r;

endmodule

### rtl/dspe_checker.sv
// port-level checks for the dag source peel engine, bound to the top level
module dspe_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input dspe_pkg::in_item_t          in_data,
  input logic                        out_valid,
  input logic                        out_ready,
  input dspe_pkg::out_item_t         out_data
);
  import dspe_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // a scan command holds off the next word
  a_scan_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_data.command == CMD_FIND || in_data.command == CMD_PEEL) |=> !in_ready)
    else $error("ready stayed high after a scan command");

  // edge writes and unused codes never stall the input
  a_write_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !(in_data.command == CMD_FIND || in_data.command == CMD_PEEL) |=> in_ready)
    else $error("ready dropped after a non-scan command");

  // a new result only comes out of a scan in progress
  a_result_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a scan in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

endmodule

bind dag_source_peel_engine dspe_checker u_dspe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### tb/sv/dag_source_peel_engine_tb.sv
// self-checking testbench for the dag source peel engine: edge writes, find and peel
module dag_source_peel_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dspe_pkg::*;

  localparam int NV = MAX_VERTICES_DEF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE = 2 * NV + 12;
  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_WORDS = 1050;
  localparam int SWEEP_LEN = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [VCNT_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  dag_source_peel_engine u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // shadow copy of the graph and the stored masks
  logic [MASK_W-1:0] graph_rows [NV];
  logic [MASK_W-1:0] entry_bits;
  logic [MASK_W-1:0] exit_bits;
  logic [VCNT_W-1:0] vtx_count;
  int unsigned vtx_rank [NV];

  out_item_t mask_expect_q[$];
  in_item_t pending_words[$];
  int unsigned words_queued = 0;
  int unsigned words_taken = 0;
  int unsigned useful_words = 0;
  int unsigned err_count = 0;
  int unsigned quiet_cycles = 0;

  function automatic int unsigned active_vertices();
    return (vtx_count > NV) ? NV : vtx_count;
  endfunction

  function automatic logic [MASK_W-1:0] low_bits(int unsigned n);
    return (n == 0) ? '0 : ({MASK_W{1'b1}} >> (MASK_W - n));
  endfunction

  // vertices below n that have an incoming edge from a vertex below n
  function automatic logic [MASK_W-1:0] fed_vertices(int unsigned n);
    logic [MASK_W-1:0] acc;
    acc = '0;
    for (int s = 0; s < n; s++) acc |= graph_rows[s];
    return acc & low_bits(n);
  endfunction

  function automatic void apply_word(in_item_t w);
    int unsigned n;
    logic [MASK_W-1:0] lm;
    logic [MASK_W-1:0] live;
    logic [MASK_W-1:0] succ;
    out_item_t res;
    n = active_vertices();
    lm = low_bits(n);
    case (w.command)
      CMD_WRITE_EDGE: begin
        graph_rows[w.src_vertex][w.dst_vertex] = w.edge_present;
      end
      CMD_FIND: begin
        entry_bits = lm & ~fed_vertices(n);
        exit_bits = '0;
        for (int v = 0; v < n; v++)
          if ((graph_rows[v] & lm) == '0) exit_bits[v] = 1'b1;
      end
      CMD_PEEL: begin
        // stale entry bits at or above n drop out here
        live = entry_bits & lm;
        succ = '0;
        for (int v = 0; v < n; v++)
          if (live[v]) succ |= graph_rows[v];
        succ &= lm;
        for (int v = 0; v < n; v++)
          if (live[v]) graph_rows[v] &= ~lm;
        entry_bits = succ & ~fed_vertices(n);
      end
      default: ;
    endcase
    if (w.command == CMD_FIND || w.command == CMD_PEEL) begin
      res.entry_mask = entry_bits;
      res.exit_mask = exit_bits;
      mask_expect_q = {mask_expect_q, res};
    end
  endfunction

  task automatic flag_mismatch(string what, logic [MASK_W-1:0] got, logic [MASK_W-1:0] want);
    $display("%0t mismatch on %s: got %h want %h", $time, what, got, want);
    err_count++;
  endtask

  function automatic void queue_word(logic [1:0] c, int unsigned s, int unsigned d, bit p);
    in_item_t w;
    w.command = c;
    w.src_vertex = VIDX_W'(s);
    w.dst_vertex = VIDX_W'(d);
    w.edge_present = p;
    pending_words = {pending_words, w};
    words_queued++;
    if (c != CMD_UNUSED) useful_words++;
  endfunction

  // find or peel with junk in the unused fields
  function automatic void queue_scan(logic [1:0] c);
    queue_word(c, $urandom_range(0, NV - 1), $urandom_range(0, NV - 1), $urandom_range(0, 1));
  endfunction

  // sender: bursts of random length, random gaps between them
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        apply_word(in_data);
        words_taken++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0 || pending_words.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left != 0) gap_left--;
        end else begin
          in_valid <= 1'b1;
          in_data <= pending_words.pop_front();
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
          end
        end
      end
    end
  end

  // receiver stall pattern: runs of always-ready, random, mostly-ready and long stalls
  int unsigned hold_mode = 0;
  int unsigned mode_left = 0;
  int unsigned tick = 0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      hold_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(40, 400);
    end else begin
      mode_left--;
    end
    tick++;
    case (hold_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 7) != 0);
      default: out_ready <= ((tick % 40) >= 30);
    endcase
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (mask_expect_q.size() == 0) begin
        flag_mismatch("unexpected word", out_data.entry_mask, out_data.exit_mask);
      end else begin
        want = mask_expect_q.pop_front();
        if (out_data.entry_mask !== want.entry_mask)
          flag_mismatch("entry_mask", out_data.entry_mask, want.entry_mask);
        if (out_data.exit_mask !== want.exit_mask)
          flag_mismatch("exit_mask", out_data.exit_mask, want.exit_mask);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // all words taken, all results back, then time for a trailing scan to settle
  task automatic wait_idle();
    do @(posedge clk);
    while (words_taken != words_queued || mask_expect_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_vertex_count(logic [VCNT_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    vtx_count = v;
  endtask

  // mostly acyclic build, find, peel runs; the rest is noise
  task automatic random_phase(int unsigned goal);
    int unsigned span;
    int unsigned u;
    int unsigned v;
    int unsigned t;
    @(negedge clk);
    while (useful_words < goal) begin
      span = active_vertices();
      if (span < 2) span = 2;
      if ($urandom_range(0, 9) < 7) begin
        repeat ($urandom_range(1, 8)) begin
          u = $urandom_range(0, span - 1);
          v = $urandom_range(0, span - 1);
          if (vtx_rank[u] > vtx_rank[v]) begin
            t = u;
            u = v;
            v = t;
          end
          if (u != v) queue_word(CMD_WRITE_EDGE, u, v, $urandom_range(0, 4) != 0);
        end
        queue_scan(CMD_FIND);
        repeat ($urandom_range(1, 6)) queue_scan(CMD_PEEL);
      end else begin
        repeat ($urandom_range(1, 6))
          queue_word(2'($urandom_range(0, 3)), $urandom_range(0, NV - 1),
                     $urandom_range(0, NV - 1), $urandom_range(0, 1));
      end
    end
  endtask

  initial begin
    int unsigned j;
    int unsigned t;
    int unsigned base;
    logic [VCNT_W-1:0] sweep [SWEEP_LEN];

    for (int i = 0; i < NV; i++) begin
      graph_rows[i] = '0;
      vtx_rank[i] = i;
    end
    for (int i = NV - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = vtx_rank[i];
      vtx_rank[i] = vtx_rank[j];
      vtx_rank[j] = t;
    end
    entry_bits = '0;
    exit_bits = '0;
    vtx_count = VCNT_RESET;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty graph, chain, self loops, unused command, peel to the end
    @(negedge clk);
    queue_word(CMD_FIND, 0, 0, 0);
    queue_word(CMD_WRITE_EDGE, 0, 1, 1);
    queue_word(CMD_WRITE_EDGE, 1, 2, 1);
    queue_word(CMD_WRITE_EDGE, 0, 31, 1);
    queue_word(CMD_WRITE_EDGE, 31, 31, 1);
    queue_word(CMD_WRITE_EDGE, 5, 5, 1);
    queue_word(CMD_WRITE_EDGE, 5, 5, 0);
    queue_word(CMD_UNUSED, 31, 31, 1);
    queue_word(CMD_FIND, 31, 31, 1);
    queue_word(CMD_PEEL, 0, 0, 0);
    queue_word(CMD_PEEL, 31, 31, 1);
    queue_word(CMD_PEEL, 0, 0, 0);
    wait_idle();

    // no vertex in use
    set_vertex_count(0);
    @(negedge clk);
    queue_word(CMD_FIND, 0, 0, 0);
    queue_word(CMD_PEEL, 0, 0, 0);
    wait_idle();

    // count above the row length saturates
    set_vertex_count(63);
    @(negedge clk);
    queue_word(CMD_FIND, 0, 0, 0);
    wait_idle();

    // stale high entries dropped at peel, edges beyond n ignored
    set_vertex_count(4);
    @(negedge clk);
    queue_word(CMD_PEEL, 0, 0, 0);
    queue_word(CMD_WRITE_EDGE, 2, 20, 1);
    queue_word(CMD_WRITE_EDGE, 20, 1, 1);
    queue_word(CMD_FIND, 0, 0, 0);
    queue_word(CMD_PEEL, 0, 0, 0);
    wait_idle();

    set_vertex_count(1);
    @(negedge clk);
    queue_word(CMD_FIND, 0, 0, 0);
    queue_word(CMD_PEEL, 0, 0, 0);
    wait_idle();

    sweep = '{6'd32, 6'd1, 6'd63, 6'd2, 6'd0, 6'd17, 6'd33, 6'd5, 6'd24, 6'd32};
    sweep[7] = VCNT_W'($urandom_range(3, 31));
    base = useful_words;
    for (int k = 0; k < SWEEP_LEN; k++) begin
      set_vertex_count(sweep[k]);
      random_phase(base + RANDOM_WORDS * (k + 1) / SWEEP_LEN);
      wait_idle();
    end

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
